// ===== hw/rtl/sps_pkg.sv =====
// sps_pkg: shared types, codes and constants of the stepper phase sequencer
// used by every rtl file of the block, no dependencies
`default_nettype none

package sps_pkg;

  localparam int POS_BITS      = 32;
  localparam int AMT_BITS      = 32;
  localparam int OP_BITS       = 3;
  localparam int SPR_BITS      = 16;
  localparam int RPM_BITS      = 10;
  localparam int PERIOD_BITS   = 26;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // period divider: 60000000 fits the period width
  localparam int DIV_BITS     = PERIOD_BITS;
  localparam int DVS_BITS     = PERIOD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam logic [DIV_BITS-1:0]    TICKS_PER_MIN  = DIV_BITS'(60000000);
  localparam logic [AMT_BITS-1:0]    DEG_PER_REV    = AMT_BITS'(360);
  localparam logic [PERIOD_BITS-1:0] PULSE_TICKS    = PERIOD_BITS'(10);
  localparam logic [PERIOD_BITS-1:0] SETUP_TICKS    = PERIOD_BITS'(2);
  localparam logic [PERIOD_BITS-1:0] RESET_PERIOD   = PERIOD_BITS'(2929);
  localparam logic [SPR_BITS-1:0]    RESET_SPR      = SPR_BITS'(2048);
  localparam logic [RPM_BITS-1:0]    RESET_RPM      = RPM_BITS'(10);

  // x / 360 as (x >> 3) / 45 by reciprocal multiply, exact over each operand range
  localparam logic [28:0] DEG_RECIP_HI = 29'd381774871;  // ceil(2^34 / 45), x < 2^32
  localparam logic [22:0] DEG_RECIP_LO = 23'd5965233;    // ceil(2^28 / 45), x < 2^25

  localparam logic [3:0] FULL_STEP_COILS [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
  localparam logic [3:0] HALF_STEP_COILS [8] =
    '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 3'd0,
    OP_STEPS   = 3'd1,
    OP_DEGREES = 3'd2,
    OP_REVS    = 3'd3,
    OP_ENABLE  = 3'd4,
    OP_DISABLE = 3'd5,
    OP_STOP    = 3'd6,
    OP_ZERO    = 3'd7
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DRIVER_KIND   = 3'd0,
    CFG_HALF_STEP     = 3'd1,
    CFG_REV_STEPS     = 3'd2,
    CFG_SPEED_RPM     = 3'd3,
    CFG_HAS_ENABLE    = 3'd4
  } cfg_e;

  // controller to datapath
  typedef struct packed {
    logic exec;         // apply an immediate operation from the input word
    logic load;         // latch a move word
    logic mul;          // register the products
    logic div_start;
    logic period_load;
    logic apply;        // start the move from the latched word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sps_if.sv =====
// sps_if: valid/ready channel interfaces of the stepper phase sequencer
// depends on sps_pkg for field widths
`default_nettype none

interface sps_in_if;
  logic                                valid;
  logic                                ready;
  logic [sps_pkg::OP_BITS-1:0]         operation;
  logic signed [sps_pkg::AMT_BITS-1:0] amount;

  modport source (output valid, output operation, output amount, input ready);
  modport sink   (input valid, input operation, input amount, output ready);
endinterface

interface sps_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        coils;
  logic              step_line;
  logic              dir_line;
  logic              enable_line;
  logic signed [31:0] position;
  logic              busy_res;
  logic              enabled;

  modport source (output valid, output coils, output step_line, output dir_line,
                  output enable_line, output position, output busy_res,
                  output enabled, input ready);
  modport sink   (input valid, input coils, input step_line, input dir_line,
                  input enable_line, input position, input busy_res,
                  input enabled, output ready);
endinterface

interface sps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sps_pkg::CFG_IDX_BITS-1:0]   index;
  logic [sps_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sps_div.sv =====
// sps_div: restoring divider, one quotient bit per cycle
// depends on sps_pkg for widths
`default_nettype none

module sps_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sps_pkg::DIV_BITS-1:0]  dividend_i,
  input  wire logic [sps_pkg::DVS_BITS-1:0]  divisor_i,
  output logic                               done_o,
  output logic [sps_pkg::DIV_BITS-1:0]       quotient_o
);

  logic                              busy_q, done_q;
  logic [sps_pkg::DIV_CNT_BITS-1:0]  cnt_q;
  logic [sps_pkg::DVS_BITS-1:0]      rem_q, dvs_q, rem_d;
  logic [sps_pkg::DIV_BITS-1:0]      quo_q;
  logic [sps_pkg::DVS_BITS:0]        trial;
  logic                              ge;

  // remainder stays below the divisor, so the trial fits one extra bit
  always_comb begin
    trial = {rem_q, quo_q[sps_pkg::DIV_BITS-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? sps_pkg::DVS_BITS'(trial - {1'b0, dvs_q})
               : trial[sps_pkg::DVS_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == sps_pkg::DIV_CNT_BITS'(sps_pkg::DIV_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[sps_pkg::DIV_BITS-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while running");

endmodule

`default_nettype wire

// ===== hw/rtl/sps_ctrl.sv =====
// sps_ctrl: handshake and sequencing controller of the stepper phase sequencer
// depends on sps_pkg for commands, status and operation codes
`default_nettype none

module sps_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [sps_pkg::OP_BITS-1:0]  operation_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire sps_pkg::status_t             status_i,
  output sps_pkg::cmd_t                     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PER_GO,
    S_PER_WAIT,
    S_APPLY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, is_move;

  always_comb begin
    in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
    accept      = in_valid_i && in_ready_o;
    is_move     = operation_i inside {sps_pkg::OP_STEPS, sps_pkg::OP_DEGREES,
                                      sps_pkg::OP_REVS};
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // a move while busy is ignored and answers at once
          if (is_move && !status_i.busy) begin
            cmd_o.load = 1'b1;
            state_d    = S_MUL;
          end else begin
            cmd_o.exec  = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PER_GO;
      end
      S_PER_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_PER_WAIT;
      end
      S_PER_WAIT: begin
        // the degree quotient settles well before the divider ends
        if (status_i.div_done) begin
          cmd_o.period_load = 1'b1;
          state_d           = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_apply_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> out_valid_o) else $error("move start gave no word");
  a_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == S_PER_WAIT)
    else $error("divider finished outside a wait state");
  a_move_no_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !out_valid_o) else $error("stale word during move start");

endmodule

`default_nettype wire

// ===== hw/rtl/sps_dp.sv =====
// sps_dp: motion state, configuration registers, multipliers and divider
// depends on sps_pkg and sps_div
`default_nettype none

module sps_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sps_pkg::cmd_t                      cmd_i,
  output sps_pkg::status_t                        status_o,
  input  wire logic [sps_pkg::OP_BITS-1:0]        operation_i,
  input  wire logic signed [sps_pkg::AMT_BITS-1:0] amount_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [sps_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [sps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic [3:0]                              coils_o,
  output logic                                    step_line_o,
  output logic                                    dir_line_o,
  output logic                                    enable_line_o,
  output logic signed [31:0]                      position_o,
  output logic                                    busy_res_o,
  output logic                                    enabled_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_HIGH,
    ST_GAP
  } stage_e;

  typedef struct packed {
    logic [2:0]                            phase;
    logic signed [sps_pkg::POS_BITS-1:0]   pos;
    logic [sps_pkg::AMT_BITS-1:0]          left;
    logic                                  fwd;
    logic [sps_pkg::PERIOD_BITS-1:0]       period;
    logic [sps_pkg::PERIOD_BITS-1:0]       wait_cnt;
    stage_e                                stage;
    logic [3:0]                            coil;
    logic                                  step;
    logic                                  dir;
  } motion_t;

  motion_t mot_q, mot_d;
  logic    en_line_q, en_line_d, en_flag_q, en_flag_d;

  logic                             kind_q, half_q, has_en_q;
  logic [sps_pkg::SPR_BITS-1:0]     spr_q, spr_eff;
  logic [sps_pkg::RPM_BITS-1:0]     rpm_q, rpm_eff;

  logic [sps_pkg::OP_BITS-1:0]      op_q;
  logic [sps_pkg::AMT_BITS-1:0]     amt_q, abs_amt, abs_q;
  logic                             neg_q;
  logic [sps_pkg::AMT_BITS-1:0]     mag_q;
  logic [sps_pkg::DVS_BITS-1:0]     prod_q;

  // degree count pipeline: |amount| = 360 * qa + ra,
  // |amount| * spr / 360 = qa * spr + ra * spr / 360
  logic [57:0]                      qa_prod;
  logic [44:0]                      rq_prod;
  logic [sps_pkg::AMT_BITS-1:0]     qa_back, ra_diff;
  logic [38:0]                      deg_mag;
  logic [22:0]                      deg_qa_q;
  logic [8:0]                       deg_ra_q;
  logic [24:0]                      deg_rs_q;
  logic [15:0]                      deg_rq_q;
  logic [sps_pkg::AMT_BITS-1:0]     deg_cnt_q;

  logic                             div_done;
  logic [sps_pkg::DIV_BITS-1:0]     div_quo;

  function automatic motion_t count_step(motion_t m);
    motion_t r;
    r = m;
    r.pos  = r.fwd ? r.pos + sps_pkg::POS_BITS'(1) : r.pos - sps_pkg::POS_BITS'(1);
    r.left = r.left - 1'b1;
    return r;
  endfunction

  function automatic motion_t begin_step(motion_t m, logic kind, logic half);
    motion_t r;
    r = m;
    if (!kind) begin
      if (r.fwd) begin
        r.phase = r.phase + 1'b1;
      end else if (r.phase == 3'd0) begin
        r.phase = half ? 3'd7 : 3'd3;
      end else begin
        r.phase = r.phase - 1'b1;
      end
      r.coil     = half ? sps_pkg::HALF_STEP_COILS[r.phase]
                        : sps_pkg::FULL_STEP_COILS[r.phase[1:0]];
      r          = count_step(r);
      r.stage    = ST_GAP;
      r.wait_cnt = r.period;
    end else begin
      r.dir      = r.fwd;
      r.stage    = ST_SETUP;
      r.wait_cnt = sps_pkg::SETUP_TICKS;
    end
    return r;
  endfunction

  function automatic motion_t end_stage(motion_t m, logic kind, logic half);
    motion_t r;
    r = m;
    case (r.stage)
      ST_SETUP: begin
        r.step     = 1'b1;
        r.stage    = ST_HIGH;
        r.wait_cnt = sps_pkg::PULSE_TICKS;
      end
      ST_HIGH: begin
        r.step     = 1'b0;
        r          = count_step(r);
        r.stage    = ST_GAP;
        r.wait_cnt = r.period;
      end
      default: begin
        if (r.left != '0) begin
          r = begin_step(r, kind, half);
        end else begin
          r.stage    = ST_IDLE;
          r.wait_cnt = '0;
          if (!kind) begin
            r.coil = '0;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic motion_t halt(motion_t m, logic kind);
    motion_t r;
    r = m;
    r.stage    = ST_IDLE;
    r.left     = '0;
    r.wait_cnt = '0;
    if (!kind) begin
      r.coil = '0;
    end else begin
      r.step = 1'b0;
    end
    return r;
  endfunction

  assign spr_eff = (spr_q == '0) ? sps_pkg::SPR_BITS'(1) : spr_q;
  assign rpm_eff = (rpm_q == '0) ? sps_pkg::RPM_BITS'(1) : rpm_q;
  assign abs_amt = amt_q[sps_pkg::AMT_BITS-1] ? (~amt_q + 1'b1) : amt_q;

  always_comb begin
    motion_t                        m;
    logic [sps_pkg::AMT_BITS-1:0]   cnt;
    m         = mot_q;
    cnt       = amt_q;
    en_line_d = en_line_q;
    en_flag_d = en_flag_q;
    if (cmd_i.exec) begin
      case (sps_pkg::op_e'(operation_i))
        sps_pkg::OP_TICK: begin
          if (m.stage != ST_IDLE) begin
            if (m.wait_cnt <= sps_pkg::PERIOD_BITS'(1)) begin
              m = end_stage(m, kind_q, half_q);
            end else begin
              m.wait_cnt = m.wait_cnt - 1'b1;
            end
          end
        end
        sps_pkg::OP_ENABLE: begin
          if (kind_q && has_en_q) begin
            en_line_d = 1'b0;
          end
          en_flag_d = 1'b1;
        end
        sps_pkg::OP_DISABLE: begin
          if (kind_q && has_en_q) begin
            en_line_d = 1'b1;
          end
          if (!kind_q) begin
            m = halt(m, kind_q);
          end
          en_flag_d = 1'b0;
        end
        sps_pkg::OP_STOP: begin
          m = halt(m, kind_q);
        end
        sps_pkg::OP_ZERO: begin
          m.pos = '0;
        end
        default: begin
          // move words that arrive while busy change nothing
        end
      endcase
    end else if (cmd_i.apply) begin
      case (sps_pkg::op_e'(op_q))
        sps_pkg::OP_DEGREES: begin
          cnt = neg_q ? (32'd0 - deg_cnt_q) : deg_cnt_q;
        end
        sps_pkg::OP_REVS: begin
          cnt = neg_q ? (32'd0 - mag_q) : mag_q;
        end
        default: begin
          cnt = amt_q;
        end
      endcase
      if (cnt == '0) begin
        if (!kind_q) begin
          m.coil = '0;
        end
      end else begin
        m.fwd  = !cnt[sps_pkg::AMT_BITS-1];
        m.left = cnt[sps_pkg::AMT_BITS-1] ? (32'd0 - cnt) : cnt;
        m      = begin_step(m, kind_q, half_q);
      end
    end
    if (cmd_i.period_load) begin
      m.period = div_quo[sps_pkg::PERIOD_BITS-1:0];
    end
    mot_d = m;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mot_q.phase    <= '0;
      mot_q.pos      <= '0;
      mot_q.left     <= '0;
      mot_q.fwd      <= 1'b1;
      mot_q.period   <= sps_pkg::RESET_PERIOD;
      mot_q.wait_cnt <= '0;
      mot_q.stage    <= ST_IDLE;
      mot_q.coil     <= '0;
      mot_q.step     <= 1'b0;
      mot_q.dir      <= 1'b0;
      en_line_q      <= 1'b1;
      en_flag_q      <= 1'b0;
    end else begin
      mot_q     <= mot_d;
      en_line_q <= en_line_d;
      en_flag_q <= en_flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= 1'b0;
      half_q   <= 1'b0;
      spr_q    <= sps_pkg::RESET_SPR;
      rpm_q    <= sps_pkg::RESET_RPM;
      has_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (sps_pkg::cfg_e'(cfg_index_i))
        sps_pkg::CFG_DRIVER_KIND:   kind_q   <= cfg_data_i[0];
        sps_pkg::CFG_HALF_STEP:     half_q   <= cfg_data_i[0];
        sps_pkg::CFG_REV_STEPS:     spr_q    <= cfg_data_i[sps_pkg::SPR_BITS-1:0];
        sps_pkg::CFG_SPEED_RPM:     rpm_q    <= cfg_data_i[sps_pkg::RPM_BITS-1:0];
        sps_pkg::CFG_HAS_ENABLE:    has_en_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // move operands and products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      amt_q <= amount_i;
    end
    if (cmd_i.mul) begin
      neg_q  <= amt_q[sps_pkg::AMT_BITS-1];
      abs_q  <= abs_amt;
      mag_q  <= abs_amt * sps_pkg::AMT_BITS'(spr_eff);
      prod_q <= sps_pkg::DVS_BITS'(rpm_eff) * sps_pkg::DVS_BITS'(spr_eff);
    end
  end

  // degree count, registered through deg_qa_q, deg_ra_q, deg_rs_q, deg_rq_q and deg_cnt_q after the operands
  assign qa_prod = 58'(abs_q[sps_pkg::AMT_BITS-1:3]) * 58'(sps_pkg::DEG_RECIP_HI);
  assign qa_back = sps_pkg::AMT_BITS'(deg_qa_q) * sps_pkg::DEG_PER_REV;
  assign ra_diff = abs_q - qa_back;
  assign rq_prod = 45'(deg_rs_q[24:3]) * 45'(sps_pkg::DEG_RECIP_LO);
  assign deg_mag = 39'(deg_qa_q) * 39'(spr_eff) + 39'(deg_rq_q);

  always_ff @(posedge clk_i) begin
    deg_qa_q  <= qa_prod[56:34];
    deg_ra_q  <= ra_diff[8:0];
    deg_rs_q  <= 25'(deg_ra_q) * 25'(spr_eff);
    deg_rq_q  <= rq_prod[43:28];
    deg_cnt_q <= deg_mag[sps_pkg::AMT_BITS-1:0];
  end

  sps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sps_pkg::TICKS_PER_MIN),
    .divisor_i  (prod_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign status_o.busy     = mot_q.stage != ST_IDLE;
  assign status_o.div_done = div_done;

  assign coils_o       = mot_q.coil;
  assign step_line_o   = mot_q.step;
  assign dir_line_o    = mot_q.dir;
  assign enable_line_o = en_line_q;
  assign position_o    = 32'(mot_q.pos);
  assign busy_res_o    = mot_q.stage != ST_IDLE;
  assign enabled_o     = en_flag_q;

  a_idle_no_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mot_q.stage == ST_IDLE |-> mot_q.left == '0) else $error("idle with steps left");

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_phase_sequencer_core.sv =====
// stepper_phase_sequencer_core: top level, joins controller and datapath
// depends on sps_pkg, sps_if, sps_ctrl, sps_dp
//
//   channel  dir  handshake          word
//   in_i     in   valid / ready      operation, amount
//   out_o    out  valid / ready      coils, step/dir/enable lines, position, flags
//   cfg_i    in   valid / ready = 1  register index, write data
//
// tick, enable, disable, stop and zero words are applied on acceptance; one is accepted
// each cycle while the previous result word is taken in the same cycle.
// a move start runs a 26-step restoring divider for the step period, with the
// degree count by a reciprocal multiply beside it, the same for every move kind.
// a pending result word blocks the next input word until it is taken.
// reset is asynchronous, active low; configuration writes are always taken.
`default_nettype none

module stepper_phase_sequencer_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sps_in_if.sink      in_i,
  sps_out_if.source   out_o,
  sps_cfg_if.sink     cfg_i
);

  sps_pkg::cmd_t    cmd;
  sps_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (in_i.operation),
    .amount_i      (in_i.amount),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .coils_o       (out_o.coils),
    .step_line_o   (out_o.step_line),
    .dir_line_o    (out_o.dir_line),
    .enable_line_o (out_o.enable_line),
    .position_o    (out_o.position),
    .busy_res_o    (out_o.busy_res),
    .enabled_o     (out_o.enabled)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for stepper_phase_sequencer_core, with a queue-fed driver,
// a ready-toggling monitor and a word-by-word motor state predictor
// depends on sps_pkg, sps_if and the rtl of the block
`default_nettype none

module tb_top;

  localparam int unsigned RUN_LIMIT = 600000;
  localparam int unsigned TICKS_MIN = 60000000;
  localparam logic [15:0] FULL_TABLE = {4'd8, 4'd4, 4'd2, 4'd1};
  localparam logic [31:0] HALF_TABLE = {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

  typedef enum logic [1:0] {
    STG_IDLE  = 2'd0,
    STG_SETUP = 2'd1,
    STG_HIGH  = 2'd2,
    STG_GAP   = 2'd3
  } pulse_stage_e;

  typedef struct {
    sps_pkg::op_e op;
    logic [31:0]  amount;
  } motor_cmd_t;

  typedef struct packed {
    logic [3:0]         coils;
    logic               step_line;
    logic               dir_line;
    logic               enable_line;
    logic signed [31:0] position;
    logic               busy;
    logic               enabled;
  } motor_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sps_in_if  in_if ();
  sps_out_if out_if ();
  sps_cfg_if cfg_if ();

  sps_pkg::op_e  drv_op     = sps_pkg::OP_TICK;
  logic [31:0]   drv_amount = '0;
  logic          drv_valid  = 1'b0;
  logic          mon_ready  = 1'b0;
  logic          cfg_valid  = 1'b0;
  sps_pkg::cfg_e cfg_index  = sps_pkg::CFG_DRIVER_KIND;
  logic [15:0]   cfg_data   = '0;

  assign in_if.valid     = drv_valid;
  assign in_if.operation = drv_op;
  assign in_if.amount    = drv_amount;
  assign out_if.ready    = mon_ready;
  assign cfg_if.valid    = cfg_valid;
  assign cfg_if.index    = cfg_index;
  assign cfg_if.data     = cfg_data;

  stepper_phase_sequencer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  motor_cmd_t  pending_cmds[$];
  motor_word_t expected_outputs[$];
  int          send_idle  = 37;
  int          recv_idle  = 71;
  int          mismatches = 0;
  int          queued_cmds = 0;
  int unsigned cycle_count = 0;

  // shadow registers
  logic        kind_q   = 1'b0;
  logic        half_q   = 1'b0;
  logic [15:0] spr_q    = 16'd2048;
  logic [9:0]  rpm_q    = 10'd10;
  logic        has_en_q = 1'b0;

  // predicted motor state
  logic [2:0]   phase_q  = '0;
  logic [31:0]  pos_q    = '0;
  logic [31:0]  left_q   = '0;
  logic         fwd_q    = 1'b1;
  logic [25:0]  period_q = 26'd2929;
  logic [25:0]  wait_q   = '0;
  pulse_stage_e stage_q  = STG_IDLE;
  logic [3:0]   coils_q  = '0;
  logic         step_q   = 1'b0;
  logic         dir_q    = 1'b0;
  logic         en_line_q = 1'b1;
  logic         en_flag_q = 1'b0;

  function automatic void count_step();
    pos_q  = fwd_q ? pos_q + 32'd1 : pos_q - 32'd1;
    left_q = left_q - 32'd1;
  endfunction

  function automatic void begin_step();
    if (!kind_q) begin
      if (fwd_q) phase_q = phase_q + 3'd1;
      else if (phase_q == 3'd0) phase_q = half_q ? 3'd7 : 3'd3;
      else phase_q = phase_q - 3'd1;
      coils_q = half_q ? HALF_TABLE[phase_q*4 +: 4] : FULL_TABLE[phase_q[1:0]*4 +: 4];
      count_step();
      stage_q = STG_GAP;
      wait_q  = period_q;
    end else begin
      dir_q   = fwd_q;
      stage_q = STG_SETUP;
      wait_q  = 26'd2;
    end
  endfunction

  function automatic void halt_motion();
    stage_q = STG_IDLE;
    left_q  = '0;
    wait_q  = '0;
    if (!kind_q) coils_q = '0;
    else step_q = 1'b0;
  endfunction

  // applies one command word to the predicted state and returns the output word
  function automatic motor_word_t next_motor_outputs(sps_pkg::op_e op, logic [31:0] amt);
    motor_word_t w;
    int unsigned spr, rpm;
    logic [31:0] count;
    longint      deg;
    case (op)
      sps_pkg::OP_TICK: begin
        if (stage_q != STG_IDLE) begin
          if (wait_q <= 26'd1) begin
            case (stage_q)
              STG_SETUP: begin
                step_q  = 1'b1;
                stage_q = STG_HIGH;
                wait_q  = 26'd10;
              end
              STG_HIGH: begin
                step_q = 1'b0;
                count_step();
                stage_q = STG_GAP;
                wait_q  = period_q;
              end
              default: begin
                if (left_q != 0) begin
                  begin_step();
                end else begin
                  stage_q = STG_IDLE;
                  wait_q  = '0;
                  if (!kind_q) coils_q = '0;
                end
              end
            endcase
          end else begin
            wait_q = wait_q - 26'd1;
          end
        end
      end
      sps_pkg::OP_STEPS, sps_pkg::OP_DEGREES, sps_pkg::OP_REVS: begin
        if (stage_q == STG_IDLE) begin
          spr = (spr_q == 0) ? 1 : spr_q;
          rpm = (rpm_q == 0) ? 1 : rpm_q;
          if (op == sps_pkg::OP_STEPS) begin
            count = amt;
          end else if (op == sps_pkg::OP_DEGREES) begin
            deg   = longint'($signed(amt));
            deg   = (deg * longint'(spr)) / 360;
            count = deg[31:0];
          end else begin
            count = amt * spr;
          end
          period_q = 26'(TICKS_MIN / (rpm * spr));
          if (count == 0) begin
            if (!kind_q) coils_q = '0;
          end else begin
            fwd_q  = ~count[31];
            left_q = count[31] ? 32'd0 - count : count;
            begin_step();
          end
        end
      end
      sps_pkg::OP_ENABLE: begin
        if (kind_q && has_en_q) en_line_q = 1'b0;
        en_flag_q = 1'b1;
      end
      sps_pkg::OP_DISABLE: begin
        if (kind_q && has_en_q) en_line_q = 1'b1;
        if (!kind_q) halt_motion();
        en_flag_q = 1'b0;
      end
      sps_pkg::OP_STOP: halt_motion();
      default: pos_q = '0;
    endcase
    w.coils       = coils_q;
    w.step_line   = step_q;
    w.dir_line    = dir_q;
    w.enable_line = en_line_q;
    w.position    = $signed(pos_q);
    w.busy        = (stage_q != STG_IDLE);
    w.enabled     = en_flag_q;
    return w;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("stepper_phase_sequencer_core test failed");
      $finish;
    end
  end

  // command driver
  always @(posedge clk_i) begin : drive_proc
    motor_cmd_t nxt;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready)
        expected_outputs.push_back(next_motor_outputs(drv_op, drv_amount));
      if (!drv_valid || in_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = pending_cmds.pop_front();
          drv_valid  <= 1'b1;
          drv_op     <= nxt.op;
          drv_amount <= nxt.amount;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin : check_proc
    motor_word_t want, got;
    if (!rst_ni) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_if.valid && mon_ready) begin
        got.coils       = out_if.coils;
        got.step_line   = out_if.step_line;
        got.dir_line    = out_if.dir_line;
        got.enable_line = out_if.enable_line;
        got.position    = out_if.position;
        got.busy        = out_if.busy_res;
        got.enabled     = out_if.enabled;
        if (expected_outputs.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("output word with no pending command at %0t", $time);
        end else begin
          want = expected_outputs.pop_front();
          if (want !== got) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch at %0t: coils %h/%h step %b/%b dir %b/%b en_line %b/%b",
                       $time, want.coils, got.coils, want.step_line, got.step_line,
                       want.dir_line, got.dir_line, want.enable_line, got.enable_line,
                       "  position %0d/%0d busy %b/%b enabled %b/%b",
                       want.position, got.position, want.busy, got.busy,
                       want.enabled, got.enabled);
          end
        end
      end
      mon_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic queue_cmd(sps_pkg::op_e op, logic [31:0] amt);
    motor_cmd_t c;
    c.op     = op;
    c.amount = amt;
    pending_cmds.push_back(c);
    queued_cmds++;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || drv_valid || expected_outputs.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(sps_pkg::cfg_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    case (idx)
      sps_pkg::CFG_DRIVER_KIND: kind_q   = value[0];
      sps_pkg::CFG_HALF_STEP:   half_q   = value[0];
      sps_pkg::CFG_REV_STEPS:   spr_q    = value;
      sps_pkg::CFG_SPEED_RPM:   rpm_q    = value[9:0];
      default:                  has_en_q = value[0];
    endcase
  endtask

  // unused upper data bits are filled with noise
  task automatic set_regs(logic kind, logic half, logic [15:0] spr, logic [9:0] rpm,
                          logic has_en);
    wait_drained();
    write_reg(sps_pkg::CFG_DRIVER_KIND, {15'($urandom_range(32767)), kind});
    write_reg(sps_pkg::CFG_HALF_STEP, {15'($urandom_range(32767)), half});
    write_reg(sps_pkg::CFG_REV_STEPS, spr);
    write_reg(sps_pkg::CFG_SPEED_RPM, {6'($urandom_range(63)), rpm});
    write_reg(sps_pkg::CFG_HAS_ENABLE, {15'($urandom_range(32767)), has_en});
  endtask

  // one move followed by a run of ticks with sparse noise, often closed by a stop
  task automatic queue_episode(bit slow);
    int           pick;
    int           n;
    logic [31:0]  amt;
    sps_pkg::op_e op;
    pick = $urandom_range(99);
    if (pick < 50) op = sps_pkg::OP_STEPS;
    else if (pick < 75) op = sps_pkg::OP_DEGREES;
    else op = sps_pkg::OP_REVS;
    if ($urandom_range(99) < 15) amt = $urandom();
    else if (op == sps_pkg::OP_STEPS) amt = 32'($urandom_range(12)) - 32'd6;
    else if (op == sps_pkg::OP_DEGREES) amt = 32'($urandom_range(6)) - 32'd3;
    else amt = 32'($urandom_range(2)) - 32'd1;
    queue_cmd(op, amt);
    n = slow ? $urandom_range(8) : $urandom_range(80);
    repeat (n) begin
      if ($urandom_range(99) < 8) queue_cmd(sps_pkg::op_e'($urandom_range(7)), $urandom());
      else queue_cmd(sps_pkg::OP_TICK, $urandom());
    end
    if (slow || $urandom_range(1)) queue_cmd(sps_pkg::OP_STOP, $urandom());
  endtask

  task automatic random_phase(int n_cmds, bit slow);
    queued_cmds = 0;
    while (queued_cmds < n_cmds) queue_episode(slow);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: half-step coils at the fastest period
    set_regs(1'b0, 1'b1, 16'd65535, 10'd1000, 1'b0);
    queue_cmd(sps_pkg::OP_TICK, 32'd0);
    queue_cmd(sps_pkg::OP_ENABLE, 32'd0);
    queue_cmd(sps_pkg::OP_STEPS, 32'd3);
    queue_cmd(sps_pkg::OP_STEPS, 32'd5);      // ignored while busy
    repeat (3) queue_cmd(sps_pkg::OP_TICK, 32'hFFFF_FFFF);
    queue_cmd(sps_pkg::OP_STEPS, -32'sd4);    // phase wraps below zero
    repeat (4) queue_cmd(sps_pkg::OP_TICK, 32'd0);
    queue_cmd(sps_pkg::OP_STEPS, 32'd0);
    queue_cmd(sps_pkg::OP_DEGREES, -32'sd1);
    queue_cmd(sps_pkg::OP_TICK, 32'd0);
    queue_cmd(sps_pkg::OP_STOP, 32'd0);
    queue_cmd(sps_pkg::OP_REVS, 32'd1);
    queue_cmd(sps_pkg::OP_DISABLE, 32'd0);    // coil mode: disable halts
    queue_cmd(sps_pkg::OP_STEPS, 32'h8000_0000);
    queue_cmd(sps_pkg::OP_TICK, 32'd0);
    queue_cmd(sps_pkg::OP_ZERO, 32'd0);
    queue_cmd(sps_pkg::OP_STOP, 32'd0);
    queue_cmd(sps_pkg::OP_DEGREES, 32'h7FFF_FFFF);
    queue_cmd(sps_pkg::OP_STOP, 32'd0);
    queue_cmd(sps_pkg::OP_DEGREES, 32'h8000_0000);
    queue_cmd(sps_pkg::OP_STOP, 32'd0);
    queue_cmd(sps_pkg::OP_REVS, 32'hFFFF_FFFF);
    queue_cmd(sps_pkg::OP_STOP, 32'd0);

    set_regs(1'b1, 1'b0, 16'd60000, 10'd1000, 1'b1);
    random_phase(200, 1'b0);
    set_regs(1'b0, 1'b0, 16'd30000, 10'd1000, 1'b0);
    random_phase(200, 1'b0);

    wait_drained();
    send_idle = 71;
    recv_idle = 37;
    set_regs(1'b0, 1'b1, 16'd65535, 10'd1000, 1'b1);
    random_phase(200, 1'b0);
    set_regs(1'b1, 1'b1, 16'd6000, 10'd1000, 1'b0);
    random_phase(200, 1'b0);

    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    // zero speed and zero steps per revolution count as one
    set_regs(1'b1, 1'b0, 16'd0, 10'd0, 1'b1);
    random_phase(120, 1'b1);
    set_regs(1'b0, 1'b0, 16'd2048, 10'd10, 1'b0);
    random_phase(120, 1'b1);
    set_regs(1'b1, 1'b0, 16'd12000, 10'd1000, 1'b1);
    random_phase(200, 1'b0);

    wait_drained();
    repeat (120) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stepper_phase_sequencer_core test passed");
    end else begin
      $display("stepper_phase_sequencer_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sps_pkg.sv
hw/rtl/sps_if.sv
hw/rtl/sps_div.sv
hw/rtl/sps_ctrl.sv
hw/rtl/sps_dp.sv
hw/rtl/stepper_phase_sequencer_core.sv
test/tb_top.sv
